// ===== sv/mqp_pkg.sv =====
// Shared types, codes and constants for the MQTT packet parser.
package mqp_pkg;

    // Longest remaining-length field, in bytes
    localparam int unsigned LENGTH_MAX_BYTES = 4;
    localparam int unsigned LEN_CNT_W        = 3;

    // Control packet types that carry a decoded body
    localparam logic [3:0] KIND_PUBLISH = 4'd3;
    localparam logic [3:0] KIND_PUBACK  = 4'd4;

    // Continuation flag and value group of a length byte
    localparam logic [7:0] LEN_CONT_MASK = 8'h80;
    localparam logic [6:0] LEN_DATA_MASK = 7'h7F;

    // Parser phase
    typedef enum logic [3:0] {
        PH_FIRST   = 4'd0,
        PH_LEN     = 4'd1,
        PH_ACK_ID  = 4'd2,
        PH_TLEN    = 4'd3,
        PH_TOPIC   = 4'd4,
        PH_PUB_ID  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_IGNORE  = 4'd7
    } phase_t;

    // Byte class codes
    typedef enum logic [2:0] {
        CLS_HEADER    = 3'd0,
        CLS_LENGTH    = 3'd1,
        CLS_TOPIC_LEN = 3'd2,
        CLS_TOPIC     = 3'd3,
        CLS_MSG_ID    = 3'd4,
        CLS_PAYLOAD   = 3'd5,
        CLS_IGNORED   = 3'd6
    } byte_class_t;

    // Parse status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_LEN_LONG  = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    // Per-packet parser state
    typedef struct packed {
        phase_t                 phase;
        logic [3:0]             kind;
        logic [1:0]             qos;
        logic [27:0]            length_acc;
        logic [LEN_CNT_W-1:0]   len_cnt;
        logic [15:0]            topic_len;
        logic [15:0]            topic_cnt;
        logic [15:0]            id;
        logic                   half;
        logic [7:0]             high_latch;
        status_t                status;
    } state_t;

    // One result item
    typedef struct packed {
        logic [7:0]   byte_value;
        byte_class_t  byte_class;
        logic [3:0]   packet_kind;
        logic [1:0]   qos_level;
        logic [27:0]  remaining_length;
        logic [15:0]  topic_length;
        logic [15:0]  message_id;
        logic         packet_end;
        status_t      parse_status;
    } result_t;

endpackage

// ===== sv/mqtt_packet_parser.sv =====
// Top level of the MQTT packet parser: input register, decoder and result register.
// An accepted input byte passes through the input register and the decoder into the result register.
// Throughput: one byte per cycle while the m_ side takes results; m_tready low holds
// both stages. The parser state loops back through the decoder alone, and both register stages advance together.
// Reset: aresetn (synchronous, active low) empties both stages and returns
// the parser to expecting the first byte with all packet fields cleared.
module mqtt_packet_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] byte_value, [10:8] byte_class,
                                   // [14:11] packet_kind, [16:15] qos_level,
                                   // [44:17] remaining_length, [60:45] topic_length,
                                   // [76:61] message_id, [78:77] parse_status, [79] zero
    output logic        m_tlast    // packet_end
);
    import mqp_pkg::*;

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_vld_reg;
    result_t     out_reg;
    state_t      state_reg;
    state_t      state_next;
    result_t     result_next;
    logic        advance;

    // Move the held request into the result stage when that stage is free
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    mqp_decode u_decode (
        .cur_state (state_reg),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .nxt_state (state_next),
        .result    (result_next)
    );

    // Parser state: update once per byte that advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= PH_FIRST;
            state_reg.kind       <= '0;
            state_reg.qos        <= '0;
            state_reg.length_acc <= '0;
            state_reg.len_cnt    <= '0;
            state_reg.topic_len  <= '0;
            state_reg.topic_cnt  <= '0;
            state_reg.id         <= '0;
            state_reg.half       <= 1'b0;
            state_reg.high_latch <= '0;
            state_reg.status     <= ST_OK;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result stage: hold until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_reg.packet_end;
    assign m_tdata  = {1'b0,
                       out_reg.parse_status,
                       out_reg.message_id,
                       out_reg.topic_length,
                       out_reg.remaining_length,
                       out_reg.qos_level,
                       out_reg.packet_kind,
                       out_reg.byte_class,
                       out_reg.byte_value};

endmodule

// ===== sv/mqp_decode.sv =====
// Combinational byte decoder: next parser state and result for one byte.
module mqp_decode (
    input  mqp_pkg::state_t  cur_state,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output mqp_pkg::state_t  nxt_state,
    output mqp_pkg::result_t result
);
    import mqp_pkg::*;

    state_t      st;
    byte_class_t cls;
    logic [15:0] pair_val;
    logic [15:0] topic_cnt_inc;
    logic [27:0] len_group;
    phase_t      body_ph;
    phase_t      after_topic_ph;

    // Assemble a big-endian pair from the latched high byte
    assign pair_val      = {cur_state.high_latch, data_byte};
    assign topic_cnt_inc = cur_state.topic_cnt + 16'd1;

    // Place the length group at its 7-bit position
    always_comb begin
        unique case (cur_state.len_cnt[1:0])
            2'd0:    len_group = {21'd0, data_byte[6:0] & LEN_DATA_MASK};
            2'd1:    len_group = {14'd0, data_byte[6:0] & LEN_DATA_MASK, 7'd0};
            2'd2:    len_group = {7'd0, data_byte[6:0] & LEN_DATA_MASK, 14'd0};
            default: len_group = {data_byte[6:0] & LEN_DATA_MASK, 21'd0};
        endcase
    end

    // Phase after the length field and after the topic
    always_comb begin
        priority if (cur_state.kind == KIND_PUBACK) begin
            body_ph = PH_ACK_ID;
        end else if (cur_state.kind == KIND_PUBLISH) begin
            body_ph = PH_TLEN;
        end else begin
            body_ph = PH_IGNORE;
        end
        priority if (cur_state.qos == 2'd0) begin
            after_topic_ph = PH_PAYLOAD;
        end else if (cur_state.qos == 2'd1) begin
            after_topic_ph = PH_PUB_ID;
        end else begin
            after_topic_ph = PH_IGNORE;
        end
    end

    // Advance the parser by one byte
    always_comb begin
        st  = cur_state;
        cls = CLS_IGNORED;
        unique case (cur_state.phase)
            PH_FIRST: begin
                cls           = CLS_HEADER;
                st.kind       = data_byte[7:4];
                st.qos        = data_byte[2:1];
                st.length_acc = '0;
                st.len_cnt    = '0;
                st.topic_len  = '0;
                st.topic_cnt  = '0;
                st.id         = '0;
                st.half       = 1'b0;
                st.high_latch = '0;
                st.status     = ST_OK;
                st.phase      = PH_LEN;
            end
            PH_LEN: begin
                cls = CLS_LENGTH;
                if (cur_state.len_cnt >= LEN_CNT_W'(LENGTH_MAX_BYTES)) begin
                    if (cur_state.status == ST_OK) begin
                        st.status = ST_LEN_LONG;
                    end
                    st.phase = PH_IGNORE;
                end else begin
                    st.length_acc = cur_state.length_acc | len_group;
                    st.len_cnt    = cur_state.len_cnt + LEN_CNT_W'(1);
                    if ((data_byte & LEN_CONT_MASK) == 8'd0) begin
                        st.phase = body_ph;
                    end
                end
            end
            PH_ACK_ID, PH_PUB_ID: begin
                cls = CLS_MSG_ID;
                if (!cur_state.half) begin
                    st.high_latch = data_byte;
                    st.half       = 1'b1;
                end else begin
                    st.half  = 1'b0;
                    st.id    = pair_val;
                    st.phase = (cur_state.phase == PH_ACK_ID) ? PH_IGNORE : PH_PAYLOAD;
                end
            end
            PH_TLEN: begin
                cls = CLS_TOPIC_LEN;
                if (!cur_state.half) begin
                    st.high_latch = data_byte;
                    st.half       = 1'b1;
                end else begin
                    st.half      = 1'b0;
                    st.topic_len = pair_val;
                    st.topic_cnt = '0;
                    st.phase     = (pair_val != 16'd0) ? PH_TOPIC : after_topic_ph;
                end
            end
            PH_TOPIC: begin
                cls          = CLS_TOPIC;
                st.topic_cnt = topic_cnt_inc;
                if (topic_cnt_inc >= cur_state.topic_len) begin
                    st.phase = after_topic_ph;
                end
            end
            PH_PAYLOAD: begin
                cls = CLS_PAYLOAD;
            end
            default: begin
                cls      = CLS_IGNORED;
                st.phase = PH_IGNORE;
            end
        endcase

        // Close the buffer: flag an early end and wait for a new header
        if (last_byte) begin
            if (st.status == ST_OK &&
                (st.phase == PH_LEN || st.phase == PH_ACK_ID || st.phase == PH_TLEN ||
                 st.phase == PH_TOPIC || st.phase == PH_PUB_ID)) begin
                st.status = ST_TRUNCATED;
            end
            st.phase = PH_FIRST;
            st.half  = 1'b0;
        end
    end

    assign nxt_state = st;

    // Result fields
    always_comb begin
        result.byte_value       = data_byte;
        result.byte_class       = cls;
        result.packet_kind      = st.kind;
        result.qos_level        = st.qos;
        result.remaining_length = st.length_acc;
        result.topic_length     = st.topic_len;
        result.message_id       = st.id;
        result.packet_end       = last_byte;
        result.parse_status     = st.status;
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the MQTT packet parser: directed and random byte streams.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mqp_pkg::*;

    // QoS levels that decide whether a message id follows the topic
    localparam logic [1:0] QOS_AT_MOST_ONCE  = 2'd0;
    localparam logic [1:0] QOS_AT_LEAST_ONCE = 2'd1;

    localparam int unsigned PIPE_LAT    = 2;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tlast;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;

    // Bytes of the packet under construction
    logic [7:0] pkt_q[$];
    // Byte reports owed by the parser, oldest first
    result_t    classified_q[$];

    // Parser state as predicted
    phase_t               pr_phase   = PH_FIRST;
    logic [3:0]           pr_kind    = '0;
    logic [1:0]           pr_qos     = '0;
    logic [27:0]          pr_len     = '0;
    logic [LEN_CNT_W-1:0] pr_len_cnt = '0;
    logic [15:0]          pr_tlen    = '0;
    logic [15:0]          pr_tcnt    = '0;
    logic [15:0]          pr_id      = '0;
    logic                 pr_half    = 1'b0;
    logic [7:0]           pr_hi      = '0;
    status_t              pr_status  = ST_OK;

    always #2 aclk = ~aclk;

    mqtt_packet_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** mqtt_packet_parser: FAILED **");
            $finish;
        end
    end

    // Stall the result side at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic string fmt_report(result_t r);
        return $sformatf("byte=%02h class=%0d kind=%0d qos=%0d len=%0d tlen=%0d id=%04h end=%0b st=%0d",
                         r.byte_value, r.byte_class, r.packet_kind, r.qos_level,
                         r.remaining_length, r.topic_length, r.message_id, r.packet_end,
                         r.parse_status);
    endfunction

    // Compare each accepted result with the oldest owed report
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.byte_value       = m_tdata[7:0];
            got.byte_class       = byte_class_t'(m_tdata[10:8]);
            got.packet_kind      = m_tdata[14:11];
            got.qos_level        = m_tdata[16:15];
            got.remaining_length = m_tdata[44:17];
            got.topic_length     = m_tdata[60:45];
            got.message_id       = m_tdata[76:61];
            got.packet_end       = m_tlast;
            got.parse_status     = status_t'(m_tdata[78:77]);
            if (classified_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %s", fmt_report(got));
            end else begin
                want = classified_q.pop_front();
                if (got.byte_value !== want.byte_value || got.byte_class !== want.byte_class ||
                    got.packet_kind !== want.packet_kind || got.qos_level !== want.qos_level ||
                    got.remaining_length !== want.remaining_length ||
                    got.topic_length !== want.topic_length ||
                    got.message_id !== want.message_id || got.packet_end !== want.packet_end ||
                    got.parse_status !== want.parse_status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch exp: %s", fmt_report(want));
                        $display("         act: %s", fmt_report(got));
                    end
                end
            end
        end
    end

    function automatic phase_t topic_done_phase(logic [1:0] qos);
        if (qos == QOS_AT_MOST_ONCE) return PH_PAYLOAD;
        if (qos == QOS_AT_LEAST_ONCE) return PH_PUB_ID;
        return PH_IGNORE;
    endfunction

    // Collect one half of a big-endian 16-bit field
    task automatic take_word_half(input logic [7:0] b, output logic done,
                                  output logic [15:0] word);
        if (!pr_half) begin
            pr_hi   = b;
            pr_half = 1'b1;
            done    = 1'b0;
            word    = '0;
        end else begin
            pr_half = 1'b0;
            done    = 1'b1;
            word    = {pr_hi, b};
        end
    endtask

    // Advance the predicted parser by one byte and queue its report
    task automatic classify_byte(input logic [7:0] b, input logic last);
        result_t     r;
        logic        done;
        logic [15:0] word;
        r.byte_class = CLS_IGNORED;
        case (pr_phase)
            PH_FIRST: begin
                r.byte_class = CLS_HEADER;
                pr_kind    = b[7:4];
                pr_qos     = b[2:1];
                pr_len     = '0;
                pr_len_cnt = '0;
                pr_tlen    = '0;
                pr_tcnt    = '0;
                pr_id      = '0;
                pr_half    = 1'b0;
                pr_hi      = '0;
                pr_status  = ST_OK;
                pr_phase   = PH_LEN;
            end
            PH_LEN: begin
                r.byte_class = CLS_LENGTH;
                if (pr_len_cnt >= LENGTH_MAX_BYTES) begin
                    if (pr_status == ST_OK) pr_status = ST_LEN_LONG;
                    pr_phase = PH_IGNORE;
                end else begin
                    pr_len = pr_len | ({21'd0, b[6:0] & LEN_DATA_MASK} << (7 * pr_len_cnt));
                    pr_len_cnt = pr_len_cnt + 1'b1;
                    if ((b & LEN_CONT_MASK) == '0)
                        pr_phase = (pr_kind == KIND_PUBACK)  ? PH_ACK_ID :
                                   (pr_kind == KIND_PUBLISH) ? PH_TLEN : PH_IGNORE;
                end
            end
            PH_ACK_ID: begin
                r.byte_class = CLS_MSG_ID;
                take_word_half(b, done, word);
                if (done) begin
                    pr_id    = word;
                    pr_phase = PH_IGNORE;
                end
            end
            PH_TLEN: begin
                r.byte_class = CLS_TOPIC_LEN;
                take_word_half(b, done, word);
                if (done) begin
                    pr_tlen  = word;
                    pr_tcnt  = '0;
                    pr_phase = (word != '0) ? PH_TOPIC : topic_done_phase(pr_qos);
                end
            end
            PH_TOPIC: begin
                r.byte_class = CLS_TOPIC;
                pr_tcnt = pr_tcnt + 16'd1;
                if (pr_tcnt >= pr_tlen) pr_phase = topic_done_phase(pr_qos);
            end
            PH_PUB_ID: begin
                r.byte_class = CLS_MSG_ID;
                take_word_half(b, done, word);
                if (done) begin
                    pr_id    = word;
                    pr_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: r.byte_class = CLS_PAYLOAD;
            default: begin
                r.byte_class = CLS_IGNORED;
                pr_phase     = PH_IGNORE;
            end
        endcase

        // Buffer end: flag anything still owed, then expect a new header
        if (last) begin
            if (pr_status == ST_OK &&
                (pr_phase == PH_LEN || pr_phase == PH_ACK_ID || pr_phase == PH_TLEN ||
                 pr_phase == PH_TOPIC || pr_phase == PH_PUB_ID))
                pr_status = ST_TRUNCATED;
            pr_phase = PH_FIRST;
            pr_half  = 1'b0;
        end

        r.byte_value       = b;
        r.packet_kind      = pr_kind;
        r.qos_level        = pr_qos;
        r.remaining_length = pr_len;
        r.topic_length     = pr_tlen;
        r.message_id       = pr_id;
        r.packet_end       = last;
        r.parse_status     = pr_status;
        classified_q.push_back(r);
    endtask

    // Offer one byte, holding it until the parser takes the request
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        classify_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_q.size(); i++)
            send_byte(pkt_q[i], i == pkt_q.size() - 1);
        pkt_q.delete();
    endtask

    // Hold off the sender until every owed report has arrived
    task automatic wait_all_reported();
        s_tvalid <= 1'b0;
        while (classified_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 4) @(posedge aclk);
    endtask

    // Append a base-128 length, low group first
    task automatic push_varint(input logic [27:0] v);
        logic [7:0] b;
        do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != '0) b = b | LEN_CONT_MASK;
            pkt_q.push_back(b);
        end while (v != '0);
    endtask

    task automatic build_publish();
        logic [1:0]  qos;
        logic [15:0] tlen;
        int unsigned plen;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        qos  = (pick < 4) ? QOS_AT_MOST_ONCE : (pick < 8) ? QOS_AT_LEAST_ONCE : 2'(pick - 6);
        tlen = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
        plen = $urandom_range(0, 10);
        pkt_q.push_back({KIND_PUBLISH, 1'($urandom), qos, 1'($urandom)});
        // Mostly a consistent length, sometimes a wide arbitrary one
        if ($urandom_range(0, 3) == 0)
            push_varint(28'($urandom) >> (7 * $urandom_range(0, 3)));
        else
            push_varint(28'(2 + tlen + plen + ((qos == QOS_AT_LEAST_ONCE) ? 2 : 0)));
        pkt_q.push_back(tlen[15:8]);
        pkt_q.push_back(tlen[7:0]);
        repeat (tlen) pkt_q.push_back(8'($urandom));
        if (qos == QOS_AT_LEAST_ONCE) repeat (2) pkt_q.push_back(8'($urandom));
        repeat (plen) pkt_q.push_back(8'($urandom));
    endtask

    task automatic build_puback();
        pkt_q.push_back({KIND_PUBACK, 4'($urandom)});
        push_varint(28'd2);
        repeat (2) pkt_q.push_back(8'($urandom));
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) pkt_q.push_back(8'($urandom));
    endtask

    task automatic build_other();
        logic [3:0]  kind;
        int unsigned n;
        kind = 4'($urandom);
        if (kind == KIND_PUBLISH || kind == KIND_PUBACK) kind = ~kind;
        n = $urandom_range(0, 5);
        pkt_q.push_back({kind, 4'($urandom)});
        push_varint(28'(n));
        repeat (n) pkt_q.push_back(8'($urandom));
    endtask

    task automatic build_well_formed();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)      build_publish();
        else if (pick < 8) build_puback();
        else               build_other();
    endtask

    // Mostly well-formed packets, the rest cut short, overlong or noise
    task automatic run_mixed_traffic(input int unsigned n_bytes);
        int unsigned target;
        int unsigned pick;
        int unsigned cut;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                build_well_formed();
                send_packet();
            end else if (pick < 87) begin
                build_well_formed();
                cut = $urandom_range(1, pkt_q.size() - 1);
                while (pkt_q.size() > cut) pkt_q.delete(pkt_q.size() - 1);
                send_packet();
            end else if (pick < 94) begin
                pkt_q.push_back(8'($urandom));
                repeat (LENGTH_MAX_BYTES) pkt_q.push_back(8'($urandom) | LEN_CONT_MASK);
                repeat ($urandom_range(1, 4)) pkt_q.push_back(8'($urandom));
                send_packet();
            end else begin
                // Noise may leave a buffer open across the next packet
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic test_edge_packets();
        set_idling(0, 0);
        // QoS 3 with dup and retain, empty topic: body ignored
        pkt_q = '{{KIND_PUBLISH, 4'hF}, 8'h03, 8'h00, 8'h00, 8'h5A};
        send_packet();
        // QoS 1 with one-byte topic, id of all ones, one payload byte
        pkt_q = '{{KIND_PUBLISH, 4'h2}, 8'h06, 8'h00, 8'h01, 8'h80, 8'hFF, 8'hFF, 8'h00};
        send_packet();
        pkt_q = '{{KIND_PUBACK, 4'h0}, 8'h02, 8'h12, 8'h34};
        send_packet();
        // Largest length, then a fifth length byte
        pkt_q = '{8'hF6, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h80, 8'h00};
        send_packet();
        pkt_q = '{8'hF6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00};
        send_packet();
        // Buffer ends with the length still owed
        pkt_q = '{{KIND_PUBLISH, 4'h0}};
        send_packet();
        wait_all_reported();
    endtask

    task automatic test_back_to_back();
        set_idling(0, 0);
        run_mixed_traffic(350);
        wait_all_reported();
    endtask

    task automatic test_sender_gaps();
        set_idling(76, 0);
        run_mixed_traffic(350);
        wait_all_reported();
    endtask

    task automatic test_receiver_stalls();
        set_idling(0, 76);
        run_mixed_traffic(350);
        wait_all_reported();
    endtask

    task automatic test_both_sides_idle();
        set_idling(15, 15);
        run_mixed_traffic(350);
        wait_all_reported();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edge_packets();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_sides_idle();
        if (mismatch_count == 0 && classified_q.size() == 0)
            $display("** mqtt_packet_parser: PASSED **");
        else
            $display("** mqtt_packet_parser: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mqp_pkg.sv
sv/mqp_decode.sv
sv/mqtt_packet_parser.sv
tb/tb.sv
